/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Implication after a fixed number of cycles.
`define ASSERT_AFTER(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ## dly (cons)) \
    else $error("delayed check failed");

`endif

/* rtl/rbc_pkg.sv */
package rbc_pkg;

  // Request function codes.
  typedef enum logic [2:0] {
    FN_LOAD_ROTOR     = 3'd0,
    FN_LOAD_REFLECTOR = 3'd1,
    FN_LOAD_INVERSE   = 3'd2,
    FN_SET_POSITION   = 3'd3,
    FN_CRYPT          = 3'd4
  } func_e;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned TableDepth = 256;

  typedef logic [ByteW-1:0] byte_t;

  // Decoded operation carried down the pipeline.
  typedef struct packed {
    logic crypt;
    logic wr_rotor;
    logic wr_refl;
    logic wr_inv;
  } op_t;

  // Contents of one pipeline stage.
  typedef struct packed {
    op_t   op;
    byte_t idx;
    byte_t data;
    byte_t fast;
    byte_t slow;
  } stage_t;

endpackage

/* rtl/rbc_ram.sv */
module rbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rotor_byte_cipher.sv */
// One-rotor byte cipher. Each input request carries a function code: load one
// entry of the rotor, reflector or inverse table, set the 16-bit stream
// position, or crypt one byte. Only a crypt request gives a result on the
// output channel; the same operation enciphers and deciphers.
// Both channels use valid/stall: a request moves at a clock edge where valid
// is high and stall is low.
// A crypt request passes through every pipeline stage and then the output
// register before showing on out_valid_o. Throughput is one request per cycle
// when nothing downstream holds it back, set by the three single-port table
// memories: each is touched once per request, in its own pipeline stage.
// Loads write each table in the stage where crypts read it, so every table
// sees reads and writes in request order with no forwarding needed.
// Reset clears the position to zero and empties the pipeline; the tables are
// not cleared and must be loaded before they are used.
// When the receiver stalls, the result is held in the output register and
// the pipeline keeps filling behind it; input stall rises only once every
// stage holds a request and the last holds a crypt waiting for the output.
module rotor_byte_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  rbc_pkg::byte_t     index_i,
  input  rbc_pkg::byte_t     data_byte_i,
  input  logic [15:0]        position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbc_pkg::byte_t     out_byte_o
);
  import rbc_pkg::*;

  localparam int unsigned NumStages = 4;

  // Stream position, advanced in request order at acceptance.
  byte_t fast_q, slow_q;

  // Pipeline: stage 0 accesses the rotor, stage 1 the reflector,
  // stage 2 the inverse table, stage 3 removes the fast offset.
  logic   [NumStages-1:0] valid_q;
  stage_t                 st_q [NumStages];
  logic   [NumStages-1:0] move;

  logic  out_valid_q;
  byte_t out_byte_q;
  logic  out_free;
  logic  accept;
  op_t   in_op;

  byte_t rot_addr, refl_addr, inv_addr;
  byte_t rot_rd, refl_rd, inv_rd;
  byte_t result;

  // Decode the incoming function code. Unused codes decode to no operation
  // and simply drain through the pipeline.
  always_comb begin
    in_op = '0;
    case (func_i)
      FN_LOAD_ROTOR:     in_op.wr_rotor = 1'b1;
      FN_LOAD_REFLECTOR: in_op.wr_refl  = 1'b1;
      FN_LOAD_INVERSE:   in_op.wr_inv   = 1'b1;
      FN_CRYPT:          in_op.crypt    = 1'b1;
      default:           in_op          = '0;
    endcase
  end

  // A stage advances when it is full and the next stage is empty or
  // advancing. Only a crypt in the last stage needs the output register.
  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    move[NumStages-1] = valid_q[NumStages-1] &&
                        (!st_q[NumStages-1].op.crypt || out_free);
    for (int k = NumStages - 2; k >= 0; k--) begin
      move[k] = valid_q[k] && (!valid_q[k+1] || move[k+1]);
    end
  end

  assign in_stall_o = valid_q[0] && !move[0];
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (!valid_q[0] || move[0]) begin
        valid_q[0] <= accept;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (!valid_q[k] || move[k]) begin
          valid_q[k] <= move[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q[0] <= '{op: in_op, idx: index_i, data: data_byte_i,
                   fast: fast_q, slow: slow_q};
    end
    for (int k = 1; k < NumStages; k++) begin
      if (move[k-1]) begin
        st_q[k] <= st_q[k-1];
      end
    end
  end

  // Position update. A set-position request loads both offsets. The fast offset
  // steps after every crypt and carries into the slow offset when it wraps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
    end else if (accept) begin
      if (func_i == FN_SET_POSITION) begin
        fast_q <= position_i[7:0];
        slow_q <= position_i[15:8];
      end else if (func_i == FN_CRYPT) begin
        fast_q <= byte_t'(fast_q + 8'd1);
        if (fast_q == '1) begin
          slow_q <= byte_t'(slow_q + 8'd1);
        end
      end
    end
  end

  // Table addresses. A crypt uses the offset-adjusted value, a load uses
  // the request's index. All sums wrap modulo 256.
  assign rot_addr  = st_q[0].op.crypt ? byte_t'(st_q[0].data + st_q[0].fast)
                                      : st_q[0].idx;
  assign refl_addr = st_q[1].op.crypt ? byte_t'(rot_rd + st_q[1].slow)
                                      : st_q[1].idx;
  assign inv_addr  = st_q[2].op.crypt ? byte_t'(refl_rd - st_q[2].slow)
                                      : st_q[2].idx;
  assign result    = byte_t'(inv_rd - st_q[3].fast);

  // Each memory is enabled only when its stage advances, so its read data
  // stays put while the request that needs it waits in the next stage.
  rbc_ram #(.Width(ByteW), .Depth(TableDepth)) u_rotor (
    .clk_i   (clk_i),
    .en_i    (move[0]),
    .we_i    (st_q[0].op.wr_rotor),
    .addr_i  (rot_addr),
    .wdata_i (st_q[0].data),
    .rdata_o (rot_rd)
  );

  rbc_ram #(.Width(ByteW), .Depth(TableDepth)) u_refl (
    .clk_i   (clk_i),
    .en_i    (move[1]),
    .we_i    (st_q[1].op.wr_refl),
    .addr_i  (refl_addr),
    .wdata_i (st_q[1].data),
    .rdata_o (refl_rd)
  );

  rbc_ram #(.Width(ByteW), .Depth(TableDepth)) u_inv (
    .clk_i   (clk_i),
    .en_i    (move[2]),
    .we_i    (st_q[2].op.wr_inv),
    .addr_i  (inv_addr),
    .wdata_i (st_q[2].data),
    .rdata_o (inv_rd)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= move[NumStages-1] && st_q[NumStages-1].op.crypt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move[NumStages-1] && st_q[NumStages-1].op.crypt) begin
      out_byte_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

/* rtl/rbc_checker.sv */
`include "assert_macros.svh"

module rbc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic [2:0]     func_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rbc_pkg::byte_t out_byte_o
);
  import rbc_pkg::*;

  // Crypt requests accepted but not yet delivered.
  logic [2:0] pending_q;
  logic       crypt_in;
  logic       crypt_out;

  assign crypt_in  = in_valid_i && !in_stall_o && (func_i == FN_CRYPT);
  assign crypt_out = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= 3'(pending_q + {2'b0, crypt_in} - {2'b0, crypt_out});
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o))
  `ASSERT_IMPLY(a_out_has_req, clk_i, rst_ni, out_valid_o, pending_q != 3'd0)
  `ASSERT_AFTER(a_latency, clk_i, rst_ni, crypt_in && (pending_q == 3'd0), 5, out_valid_o)
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, pending_q >= 3'd2)

endmodule

bind rotor_byte_cipher rbc_checker u_rbc_checker (.*);
